// ----- design/jcs_pkg.sv -----
// shared types, constants and helpers of the joint constraint solver
package jcs_pkg;

    localparam int unsigned NumAx     = 3;
    localparam int unsigned FieldW    = 32;
    localparam int unsigned InW       = 12 * FieldW;
    localparam int unsigned OutW      = 9 * FieldW;
    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned DivSteps  = 17;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoAw    = 2;

    localparam logic [31:0] STIFF_RESET = 32'd6553600;
    localparam logic [31:0] DAMP_RESET  = 32'd655360;
    localparam logic [63:0] THRESH_SQ   = 64'd4294;

    typedef enum logic [1:0] {
        KIND_FIXED  = 2'd0,
        KIND_SPRING = 2'd1,
        KIND_BALL   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_KIND  = 3'd0,
        REG_OFF_X = 3'd1,
        REG_OFF_Y = 3'd2,
        REG_OFF_Z = 3'd3,
        REG_STIFF = 3'd4,
        REG_DAMP  = 3'd5,
        REG_REST  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_kind            kind;
        logic [2:0][31:0] off;
        logic [31:0]      stiff;
        logic [31:0]      damp;
        logic [31:0]      rest;
    } t_cfg;

    // item as classified by the front end
    typedef struct packed {
        logic [2:0][31:0] pa;
        logic [2:0][31:0] pb;
        logic [2:0][34:0] d;
        logic [2:0][31:0] ds;
        logic [2:0][32:0] dv;
        logic             dsat;
        logic [2:0][63:0] sq;
    } t_entry;

    // payload carried down the back-end pipeline
    typedef struct packed {
        logic [2:0][31:0] na;
        logic [2:0][31:0] nb;
        logic [2:0][31:0] ds;
        logic [2:0][32:0] dv;
        logic             spring;
        logic             bsat;
    } t_carry;

    // {clamped, value}
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// ----- design/jcs_front.sv -----
// front end: accepts items, forms the anchor delta and its squared components
module jcs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [jcs_pkg::InW-1:0]    s_axis_tdata,
    input  jcs_pkg::t_cfg              i_cfg,
    output logic                       o_push,
    output jcs_pkg::t_entry            o_entry,
    input  logic                       i_full
);
    import jcs_pkg::*;

    logic [2:0][31:0] pa, pb, va, vb;
    logic [2:0][34:0] d;
    logic [2:0][31:0] ds;
    logic [2:0][32:0] dv;
    logic             dsat;

    logic             r_vld;
    logic [2:0][31:0] r_pa, r_pb, r_ds;
    logic [2:0][34:0] r_d;
    logic [2:0][32:0] r_dv;
    logic             r_dsat;

    logic take;

    always_comb begin
        logic [32:0] sres;
        dsat = 1'b0;
        for (int i = 0; i < NumAx; i++) begin
            pa[i] = s_axis_tdata[FieldW*i +: FieldW];
            pb[i] = s_axis_tdata[FieldW*(3+i) +: FieldW];
            va[i] = s_axis_tdata[FieldW*(6+i) +: FieldW];
            vb[i] = s_axis_tdata[FieldW*(9+i) +: FieldW];
            d[i]  = 35'($signed(pb[i])) - 35'($signed(pa[i])) + 35'($signed(i_cfg.off[i]));
            sres  = sat32(64'($signed(d[i])));
            ds[i] = sres[31:0];
            dsat  = dsat | sres[32];
            dv[i] = 33'($signed(vb[i])) - 33'($signed(va[i]));
        end
    end

    assign o_push        = r_vld && !i_full;
    assign s_axis_tready = !r_vld || !i_full;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pa   <= pa;
            r_pb   <= pb;
            r_d    <= d;
            r_ds   <= ds;
            r_dv   <= dv;
            r_dsat <= dsat;
        end
    end

    always_comb begin
        logic signed [63:0] sq_t;
        o_entry.pa   = r_pa;
        o_entry.pb   = r_pb;
        o_entry.d    = r_d;
        o_entry.ds   = r_ds;
        o_entry.dv   = r_dv;
        o_entry.dsat = r_dsat;
        for (int i = 0; i < NumAx; i++) begin
            sq_t          = $signed(r_ds[i]) * $signed(r_ds[i]);
            o_entry.sq[i] = sq_t;
        end
    end

endmodule

// ----- design/jcs_fifo.sv -----
// short queue between front end and back end
module jcs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jcs_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output jcs_pkg::t_entry o_data,
    output logic            o_empty
);
    import jcs_pkg::*;

    localparam logic [FifoAw:0] CntFull = (FifoAw+1)'(FifoDepth);

    t_entry            r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wp, r_rp;
    logic [FifoAw:0]   r_cnt;

    assign o_full  = (r_cnt == CntFull);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- design/jcs_back.sv -----
// back end: root, unit vector divide, damping projection and force pipeline
module jcs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    output logic                       o_pop,
    input  jcs_pkg::t_entry            i_entry,
    input  jcs_pkg::t_cfg              i_cfg,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [jcs_pkg::OutW-1:0]   m_axis_tdata,
    output logic                       m_axis_tuser
);
    import jcs_pkg::*;

    logic en;

    // entry stage
    logic [63:0] s_sum;
    t_carry      s_c;

    // root stages, index 0 is the entry stage
    logic        r_rvld [SqrtSteps+1];
    logic [63:0] r_rv   [SqrtSteps+1];
    logic [63:0] r_rr   [SqrtSteps+1];
    t_carry      r_rc   [SqrtSteps+1];

    // divide stages
    logic             r_qvld [DivSteps+1];
    logic [31:0]      r_len  [DivSteps+1];
    logic [2:0][31:0] r_rem  [DivSteps+1];
    logic [2:0][16:0] r_q    [DivSteps+1];
    t_carry           r_qc   [DivSteps+1];
    logic [2:0]       r_dbit;

    logic [2:0][17:0] u;

    logic                    r_p1_vld;
    t_carry                  r_p1_c;
    logic [31:0]             r_p1_len;
    logic [2:0][17:0]        r_p1_u;
    logic [2:0][50:0]        r_p1_prod;

    logic                    r_p2_vld;
    t_carry                  r_p2_c;
    logic [31:0]             r_p2_len;
    logic [2:0][17:0]        r_p2_u;
    logic signed [35:0]      r_p2_p;

    logic                    r_m1_vld;
    t_carry                  r_m1_c;
    logic [2:0][17:0]        r_m1_u;
    logic [63:0]             r_m1_prod1;
    logic [65:0]             r_m1_prod2;
    logic                    r_m1_s1, r_m1_s2;

    logic                    r_m2_vld;
    t_carry                  r_m2_c;
    logic [2:0][17:0]        r_m2_u;
    logic signed [51:0]      r_m2_mag;

    logic                    r_f1_vld;
    t_carry                  r_f1_c;
    logic [2:0][67:0]        r_f1_prod;
    logic [2:0]              r_f1_neg;

    logic                    r_o_vld;
    logic [OutW-1:0]         r_o_data;
    logic                    r_o_user;

    assign en    = !r_o_vld || m_axis_tready;
    assign o_pop = en && i_vld;

    // squared length, threshold test and the half-delta moves
    always_comb begin
        logic signed [34:0] half;
        logic [32:0]        ra, rb;
        logic               psat;
        logic               thr;
        s_sum     = i_entry.sq[0] + i_entry.sq[1] + i_entry.sq[2];
        thr       = s_sum > THRESH_SQ;
        psat      = 1'b0;
        s_c.ds    = i_entry.ds;
        s_c.dv    = i_entry.dv;
        s_c.na    = i_entry.pa;
        s_c.nb    = i_entry.pb;
        for (int i = 0; i < NumAx; i++) begin
            // halving rounds toward zero
            half = ($signed(i_entry.d[i]) + $signed({34'd0, i_entry.d[i][34]})) >>> 1;
            ra   = sat32(64'($signed(i_entry.pa[i])) + 64'(half));
            rb   = sat32(64'($signed(i_entry.pb[i])) - 64'(half));
            if ((i_cfg.kind == KIND_FIXED || i_cfg.kind == KIND_BALL) && thr) begin
                s_c.na[i] = ra[31:0];
                s_c.nb[i] = rb[31:0];
                psat      = psat | ra[32] | rb[32];
            end
        end
        s_c.spring = (i_cfg.kind == KIND_SPRING) && (s_sum != '0);
        s_c.bsat   = psat | (s_c.spring & i_entry.dsat);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SqrtSteps; k++) begin
                r_rvld[k] <= 1'b0;
            end
            for (int k = 0; k <= DivSteps; k++) begin
                r_qvld[k] <= 1'b0;
            end
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_f1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (en) begin
            r_rvld[0] <= i_vld;
            for (int k = 0; k < SqrtSteps; k++) begin
                r_rvld[k+1] <= r_rvld[k];
            end
            r_qvld[0] <= r_rvld[SqrtSteps];
            for (int k = 0; k < DivSteps; k++) begin
                r_qvld[k+1] <= r_qvld[k];
            end
            r_p1_vld <= r_qvld[DivSteps];
            r_p2_vld <= r_p1_vld;
            r_m1_vld <= r_p2_vld;
            r_m2_vld <= r_m1_vld;
            r_f1_vld <= r_m2_vld;
            r_o_vld  <= r_f1_vld;
        end
    end

    // integer root, one result bit per stage
    always_ff @(posedge i_clk) begin
        logic [63:0] trial;
        logic [63:0] bitv;
        if (en) begin
            r_rv[0] <= s_sum;
            r_rr[0] <= '0;
            r_rc[0] <= s_c;
            for (int k = 0; k < SqrtSteps; k++) begin
                bitv       = 64'd1 << (62 - 2*k);
                trial      = r_rr[k] + bitv;
                r_rc[k+1] <= r_rc[k];
                if (r_rv[k] >= trial) begin
                    r_rv[k+1] <= r_rv[k] - trial;
                    r_rr[k+1] <= (r_rr[k] >> 1) + bitv;
                end else begin
                    r_rv[k+1] <= r_rv[k];
                    r_rr[k+1] <= r_rr[k] >> 1;
                end
            end
        end
    end

    // |ds| * 65536 / len, restoring, one quotient bit per stage on three lanes
    always_ff @(posedge i_clk) begin
        logic [31:0] mag;
        logic [32:0] t;
        if (en) begin
            r_len[0] <= r_rr[SqrtSteps][31:0];
            r_qc[0]  <= r_rc[SqrtSteps];
            for (int i = 0; i < NumAx; i++) begin
                mag          = r_rc[SqrtSteps].ds[i][31] ? (32'd0 - r_rc[SqrtSteps].ds[i])
                                                        : r_rc[SqrtSteps].ds[i];
                r_rem[0][i] <= {1'b0, mag[31:1]};
                r_dbit[i]   <= mag[0];
                r_q[0][i]   <= '0;
            end
            for (int k = 0; k < DivSteps; k++) begin
                r_len[k+1] <= r_len[k];
                r_qc[k+1]  <= r_qc[k];
                for (int i = 0; i < NumAx; i++) begin
                    t = {r_rem[k][i], (k == 0) ? r_dbit[i] : 1'b0};
                    if (t >= {1'b0, r_len[k]}) begin
                        r_rem[k+1][i] <= 32'(t - {1'b0, r_len[k]});
                        r_q[k+1][i]   <= {r_q[k][i][15:0], 1'b1};
                    end else begin
                        r_rem[k+1][i] <= t[31:0];
                        r_q[k+1][i]   <= {r_q[k][i][15:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NumAx; i++) begin
            u[i] = r_qc[DivSteps].ds[i][31] ? (18'd0 - {1'b0, r_q[DivSteps][i]})
                                            : {1'b0, r_q[DivSteps][i]};
        end
    end

    // projection of relative velocity, spring magnitude and force
    always_ff @(posedge i_clk) begin
        logic signed [50:0] pr;
        logic signed [52:0] dot;
        logic signed [52:0] p_t;
        logic signed [33:0] a;
        logic [33:0]        amag;
        logic [35:0]        pabs;
        logic [47:0]        t1;
        logic [49:0]        t2;
        logic signed [51:0] v1, v2;
        logic [51:0]        magm;
        logic [17:0]        umag;
        logic [51:0]        r;
        logic signed [63:0] fv;
        logic [32:0]        fs;
        logic [2:0][31:0]   f;
        logic               fsat;
        if (en) begin
            r_p1_c   <= r_qc[DivSteps];
            r_p1_len <= r_len[DivSteps];
            r_p1_u   <= u;
            for (int i = 0; i < NumAx; i++) begin
                pr = $signed(r_qc[DivSteps].dv[i]) * $signed(u[i]);
                r_p1_prod[i] <= pr;
            end

            dot = 53'($signed(r_p1_prod[0])) + 53'($signed(r_p1_prod[1]))
                + 53'($signed(r_p1_prod[2]));
            // divide by 65536 rounding toward zero
            p_t = (dot + (dot[52] ? 53'sd65535 : 53'sd0)) >>> 16;
            r_p2_c   <= r_p1_c;
            r_p2_len <= r_p1_len;
            r_p2_u   <= r_p1_u;
            r_p2_p   <= p_t[35:0];

            a    = $signed({2'b00, r_p2_len}) - $signed({2'b00, i_cfg.rest});
            amag = a[33] ? (34'd0 - a) : a;
            pabs = r_p2_p[35] ? (36'd0 - r_p2_p) : r_p2_p;
            r_m1_c     <= r_p2_c;
            r_m1_u     <= r_p2_u;
            r_m1_prod1 <= amag[31:0] * i_cfg.stiff;
            r_m1_prod2 <= pabs[33:0] * i_cfg.damp;
            r_m1_s1    <= a[33];
            r_m1_s2    <= r_p2_p[35];

            t1 = r_m1_prod1[63:16];
            t2 = r_m1_prod2[65:16];
            v1 = r_m1_s1 ? -$signed({4'b0000, t1}) : $signed({4'b0000, t1});
            v2 = r_m1_s2 ? -$signed({2'b00, t2})   : $signed({2'b00, t2});
            r_m2_c   <= r_m1_c;
            r_m2_u   <= r_m1_u;
            r_m2_mag <= v1 - v2;

            magm = r_m2_mag[51] ? (52'd0 - r_m2_mag) : r_m2_mag;
            r_f1_c <= r_m2_c;
            for (int i = 0; i < NumAx; i++) begin
                umag = r_m2_u[i][17] ? (18'd0 - r_m2_u[i]) : r_m2_u[i];
                r_f1_prod[i] <= magm[50:0] * umag[16:0];
                r_f1_neg[i]  <= r_m2_mag[51] ^ r_m2_u[i][17];
            end

            fsat = 1'b0;
            for (int i = 0; i < NumAx; i++) begin
                r    = r_f1_prod[i][67:16];
                fv   = r_f1_neg[i] ? -$signed({12'd0, r}) : $signed({12'd0, r});
                fs   = sat32(fv);
                f[i] = r_f1_c.spring ? fs[31:0] : 32'd0;
                fsat = fsat | fs[32];
            end
            r_o_data <= {f, r_f1_c.nb, r_f1_c.na};
            r_o_user <= r_f1_c.bsat | (r_f1_c.spring & fsat);
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

endmodule

// ----- design/joint_constraint_solver_core.sv -----
// Joint constraint solver: one joint solve per item, fixed, ball, spring or no-op kind.
// tdata in: pos_a x,y,z, pos_b x,y,z, vel_a x,y,z, vel_b x,y,z, 32 bits each. Takes one
// item per clock while not back-pressured, returning one result item per item, in order,
// via the front stage, the queue, the 32-stage integer square root and the 17-stage
// pipelined divide that forms the unit vector. Configuration registers must be written
// through the plain write port while no item is in flight; the core does not enforce it.
module joint_constraint_solver_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
    // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z
    input  logic [jcs_pkg::InW-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // new_pos_a_x, new_pos_a_y, new_pos_a_z, new_pos_b_x, new_pos_b_y, new_pos_b_z,
    // force_on_a_x, force_on_a_y, force_on_a_z
    output logic [jcs_pkg::OutW-1:0]   m_axis_tdata,
    // saturated
    output logic                       m_axis_tuser,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [31:0]                i_cfg_wdata
);
    import jcs_pkg::*;

    t_cfg   r_cfg;
    t_entry front_entry, queue_entry;
    logic   push, full, pop, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind  <= KIND_FIXED;
            r_cfg.off   <= '0;
            r_cfg.stiff <= STIFF_RESET;
            r_cfg.damp  <= DAMP_RESET;
            r_cfg.rest  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KIND:  r_cfg.kind   <= t_kind'(i_cfg_wdata[1:0]);
                REG_OFF_X: r_cfg.off[0] <= i_cfg_wdata;
                REG_OFF_Y: r_cfg.off[1] <= i_cfg_wdata;
                REG_OFF_Z: r_cfg.off[2] <= i_cfg_wdata;
                REG_STIFF: r_cfg.stiff  <= i_cfg_wdata;
                REG_DAMP:  r_cfg.damp   <= i_cfg_wdata;
                REG_REST:  r_cfg.rest   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    jcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg         (r_cfg),
        .o_push        (push),
        .o_entry       (front_entry),
        .i_full        (full)
    );

    jcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_entry),
        .o_empty (empty)
    );

    jcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (!empty),
        .o_pop         (pop),
        .i_entry       (queue_entry),
        .i_cfg         (r_cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
